/* sv/wcmt_pkg.sv */
// ----------------------------------------------------------------------------
// wcmt_pkg
// Shared types, constants and helpers for the worker clock minimum tracker.
// ----------------------------------------------------------------------------
package wcmt_pkg;

   // Default table depth
   localparam int MAX_WORKERS_DEF = 64;

   // Field widths
   localparam int REQ_W   = 2;
   localparam int ID_W    = 6;
   localparam int CLOCK_W = 31;
   localparam int MIN_W   = 32;

   localparam logic [CLOCK_W-1:0]      CLOCK_MAX = '1;
   localparam logic signed [MIN_W-1:0] NO_MIN    = -32'sd1;

   // Request codes; the remaining code behaves as a read
   localparam logic [REQ_W-1:0] REQ_SET  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_UNKNOWN = 1'b1;

   // One table word: known flag plus worker clock
   typedef struct packed {
      logic               valid;
      logic [CLOCK_W-1:0] clock;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SCAN
   } state_type;

   // Saturating clock increment
   function automatic logic [CLOCK_W-1:0] sat_inc(input logic [CLOCK_W-1:0] v);
      return (v == CLOCK_MAX) ? v : v + 1'b1;
   endfunction

endpackage

/* sv/wcmt_table.sv */
// ----------------------------------------------------------------------------
// wcmt_table
// Worker table RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wcmt_table
   import wcmt_pkg::*;
#(
   parameter int  DEPTH = MAX_WORKERS_DEF,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/worker_clock_min_tracker.sv */
// ----------------------------------------------------------------------------
// worker_clock_min_tracker
// Per-worker clock table with a global minimum clock.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps every table entry to unknown with
// busy high, then accepts a request whenever start is high and busy is low.
// Every request gives exactly one response, shown for one cycle on the rsp_
// ports with rsp_valid high; the receiver cannot stall it. A set, a read or
// a tick that does not touch the minimum is answered from the fetch state;
// a request with a worker id not below MAX_WORKERS is answered at once. A
// tick of a worker whose clock equals the minimum walks the whole table
// through the single RAM read port, one entry per cycle, to count workers
// at the minimum.
// ----------------------------------------------------------------------------
module worker_clock_min_tracker
   import wcmt_pkg::*;
#(
   parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [REQ_W-1:0]         req_type,
   input  logic [ID_W-1:0]          req_worker_id,
   input  logic [CLOCK_W-1:0]       req_clock_value,
   output logic                     rsp_valid,
   output logic                     rsp_status,
   output logic [CLOCK_W-1:0]       rsp_worker_clock,
   output logic signed [MIN_W-1:0]  rsp_min_clock,
   output logic [CLOCK_W-1:0]       rsp_tick_result
);

   localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W = $clog2(MAX_WORKERS + 1);
   localparam int CMP_W = (IDX_W + 1 > ID_W + 1) ? IDX_W + 1 : ID_W + 1;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_WORKERS - 1);
   localparam logic [CNT_W-1:0] SCAN_DONE = CNT_W'(MAX_WORKERS);

   state_type state_ff, state_in;

   // Held request
   logic [REQ_W-1:0]   op_ff,  op_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CLOCK_W-1:0] val_ff, val_in;
   logic [CLOCK_W-1:0] cur_ff, cur_in;

   // Scan and clear
   logic [CNT_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [1:0]         hits_ff, hits_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;

   logic signed [MIN_W-1:0] min_ff, min_in;

   // Response registers
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [CLOCK_W-1:0]      rsp_wclk_ff,   rsp_wclk_in;
   logic signed [MIN_W-1:0] rsp_min_ff,    rsp_min_in;
   logic [CLOCK_W-1:0]      rsp_tres_ff,   rsp_tres_in;

   // RAM ports
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   entry_type               mem_wdata;
   logic [IDX_W-1:0]        mem_raddr;
   entry_type               mem_rdata;

   logic                    accept;
   logic                    in_range;
   logic [CLOCK_W-1:0]      fetch_cur;
   logic                    tick_at_min;
   logic                    scan_match;
   logic [1:0]              hits_sum;
   logic                    scan_last;
   logic [CLOCK_W-1:0]      cur_inc;

   wcmt_table #(
      .DEPTH (MAX_WORKERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Handshake and request decode
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = CMP_W'(req_worker_id) < CMP_W'(MAX_WORKERS);

   // Tick candidate: the (possibly new) worker sits at the minimum
   assign fetch_cur   = mem_rdata.valid ? mem_rdata.clock : '0;
   assign tick_at_min = !min_ff[MIN_W-1] && ({1'b0, fetch_cur} == min_ff);

   // Scan counting; read data lags the address through the registered read port
   assign scan_match = (scan_cnt_ff != '0) && mem_rdata.valid
                       && ({1'b0, mem_rdata.clock} == min_ff);
   assign hits_sum   = (hits_ff == 2'd2) ? hits_ff : hits_ff + {1'b0, scan_match};
   assign scan_last  = (scan_cnt_ff == SCAN_DONE);
   assign cur_inc    = sat_inc(cur_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && in_range) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if ((op_ff == REQ_TICK) && tick_at_min) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM control and responses
   always_comb begin
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      scan_cnt_in   = scan_cnt_ff;
      hits_in       = hits_ff;
      clr_in        = clr_ff;
      min_in        = min_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_wclk_in   = rsp_wclk_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_tres_in   = rsp_tres_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = '{valid: 1'b1, clock: val_ff};
      mem_raddr     = IDX_W'(req_worker_id);

      case (state_ff)
         // Sweep the table to all unknown
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end

         // Take a request; out-of-range ids answer at once
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_type;
               idx_in = IDX_W'(req_worker_id);
               val_in = req_clock_value;
               if (!in_range) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_UNKNOWN;
                  rsp_wclk_in   = '0;
                  rsp_min_in    = min_ff;
                  rsp_tres_in   = '0;
               end
            end
         end

         // Entry is on the read port
         ST_FETCH: begin
            rsp_status_in = STATUS_OK;
            rsp_tres_in   = '0;
            rsp_min_in    = min_ff;
            case (op_ff)
               REQ_SET: begin
                  mem_we      = 1'b1;
                  mem_wdata   = '{valid: 1'b1, clock: val_ff};
                  rsp_valid_in = 1'b1;
                  rsp_wclk_in = val_ff;
                  if ((min_ff == NO_MIN) || ($signed({1'b0, val_ff}) < min_ff)) begin
                     min_in     = $signed({1'b0, val_ff});
                     rsp_min_in = $signed({1'b0, val_ff});
                  end
               end
               REQ_TICK: begin
                  cur_in = fetch_cur;
                  mem_we = 1'b1;
                  if (tick_at_min) begin
                     // store the created entry so the scan counts it
                     mem_wdata   = '{valid: 1'b1, clock: fetch_cur};
                     scan_cnt_in = '0;
                     hits_in     = '0;
                  end else begin
                     mem_wdata    = '{valid: 1'b1, clock: sat_inc(fetch_cur)};
                     rsp_valid_in = 1'b1;
                     rsp_wclk_in  = sat_inc(fetch_cur);
                  end
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mem_rdata.valid ? STATUS_OK : STATUS_UNKNOWN;
                  rsp_wclk_in   = fetch_cur;
               end
            endcase
         end

         // Count known workers at the minimum, one entry per cycle
         ST_SCAN: begin
            mem_raddr   = scan_cnt_ff[IDX_W-1:0];
            scan_cnt_in = scan_cnt_ff + 1'b1;
            hits_in     = hits_sum;
            if (scan_last) begin
               mem_we        = 1'b1;
               mem_wdata     = '{valid: 1'b1, clock: cur_inc};
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_wclk_in   = cur_inc;
               if (hits_sum == 2'd1) begin
                  min_in      = $signed({1'b0, cur_inc});
                  rsp_min_in  = $signed({1'b0, cur_inc});
                  rsp_tres_in = cur_inc;
               end else begin
                  rsp_min_in  = min_ff;
                  rsp_tres_in = '0;
               end
            end
         end

         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         min_ff       <= NO_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      scan_cnt_ff   <= scan_cnt_in;
      hits_ff       <= hits_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wclk_ff   <= rsp_wclk_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_tres_ff   <= rsp_tres_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_worker_clock = rsp_wclk_ff;
   assign rsp_min_clock    = rsp_min_ff;
   assign rsp_tick_result  = rsp_tres_ff;

endmodule

/* verif/worker_clock_min_tracker_tb.sv */
// ----------------------------------------------------------------------------
// worker_clock_min_tracker_tb
// Self-checking bench for the worker clock minimum tracker. Requests are sent
// through the start/busy handshake with random idle gaps. A predictor keeps a
// shadow clock table and minimum, and every response is compared field by
// field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module worker_clock_min_tracker_tb;
   import wcmt_pkg::*;

   localparam int TABLE_DEPTH = MAX_WORKERS_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
   localparam int POOL_LAST = 5;

   // Code 3 decodes as a read
   localparam logic [REQ_W-1:0] REQ_READ_ALT = 2'd3;

   typedef struct packed {
      logic                     status;
      logic [CLOCK_W-1:0]       worker_clock;
      logic signed [MIN_W-1:0]  min_clock;
      logic [CLOCK_W-1:0]       tick_result;
   } tracker_result_type;

   // DUT signals
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [REQ_W-1:0]        req_type = REQ_READ;
   logic [ID_W-1:0]         req_worker_id = '0;
   logic [CLOCK_W-1:0]      req_clock_value = '0;
   logic                    rsp_valid;
   logic                    rsp_status;
   logic [CLOCK_W-1:0]      rsp_worker_clock;
   logic signed [MIN_W-1:0] rsp_min_clock;
   logic [CLOCK_W-1:0]      rsp_tick_result;

   // Shadow state of the tracker
   logic [CLOCK_W-1:0]      shadow_clock [TABLE_DEPTH];
   logic                    shadow_known [TABLE_DEPTH];
   logic signed [MIN_W-1:0] shadow_min;

   tracker_result_type pending_results[$];

   int  failures = 0;
   int  cycle_count = 0;
   int  set_count = 0;
   int  tick_count = 0;
   int  read_count = 0;
   int  advance_count = 0;
   int  saturated_count = 0;
   bit  no_idle = 1'b0;

   worker_clock_min_tracker u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_worker_id    (req_worker_id),
      .req_clock_value  (req_clock_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_worker_clock (rsp_worker_clock),
      .rsp_min_clock    (rsp_min_clock),
      .rsp_tick_result  (rsp_tick_result)
   );

   // 10-unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  pending_results.size());
         $display("FAIL worker_clock_min_tracker");
         $finish;
      end
   end

   // Saturating increment of a worker clock
   function automatic logic [CLOCK_W-1:0] clock_bump(input logic [CLOCK_W-1:0] v);
      logic [CLOCK_W-1:0] top;
      top = '1;
      return (v == top) ? v : v + 1'b1;
   endfunction

   // Apply one accepted request to the shadow state, give its response
   function automatic tracker_result_type apply_request(input logic [REQ_W-1:0] kind,
                                                        input logic [ID_W-1:0] id,
                                                        input logic [CLOCK_W-1:0] value);
      tracker_result_type r;
      int  holders;
      bit  alone;
      r = '0;
      holders = 0;
      alone = 1'b0;
      if (int'(id) >= TABLE_DEPTH) begin
         r.status = STATUS_UNKNOWN;
      end else begin
         case (kind)
            REQ_SET: begin
               shadow_clock[id] = value;
               shadow_known[id] = 1'b1;
               if (shadow_min == NO_MIN || $signed({1'b0, value}) < shadow_min)
                  shadow_min = $signed({1'b0, value});
               r.worker_clock = value;
            end
            REQ_TICK: begin
               if (!shadow_known[id]) begin
                  shadow_clock[id] = '0;
                  shadow_known[id] = 1'b1;
               end
               // Only a worker sitting on the minimum can move it
               if (shadow_min >= 0 && $signed({1'b0, shadow_clock[id]}) == shadow_min) begin
                  for (int i = 0; i < TABLE_DEPTH; i++)
                     if (shadow_known[i] && $signed({1'b0, shadow_clock[i]}) == shadow_min)
                        holders++;
                  alone = (holders == 1);
               end
               shadow_clock[id] = clock_bump(shadow_clock[id]);
               if (alone) begin
                  shadow_min = $signed({1'b0, clock_bump(shadow_min[CLOCK_W-1:0])});
                  r.tick_result = shadow_min[CLOCK_W-1:0];
               end
               r.worker_clock = shadow_clock[id];
            end
            default: begin
               if (shadow_known[id])
                  r.worker_clock = shadow_clock[id];
               else
                  r.status = STATUS_UNKNOWN;
            end
         endcase
      end
      r.min_clock = shadow_min;
      return r;
   endfunction

   // Response check, then prediction of any request taken at this edge
   always @(posedge clock) begin
      tracker_result_type want;
      tracker_result_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_status, rsp_worker_clock, rsp_min_clock, rsp_tick_result};
            if (pending_results.size() == 0) begin
               $display("%0t: response with no request pending (status %0d clock %0d min %0d)",
                        $time, got.status, got.worker_clock, got.min_clock);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
                  failures++;
               end
               if (got.worker_clock !== want.worker_clock) begin
                  $display("%0t: worker_clock expected %0d actual %0d", $time,
                           want.worker_clock, got.worker_clock);
                  failures++;
               end
               if (got.min_clock !== want.min_clock) begin
                  $display("%0t: min_clock expected %0d actual %0d", $time,
                           want.min_clock, got.min_clock);
                  failures++;
               end
               if (got.tick_result !== want.tick_result) begin
                  $display("%0t: tick_result expected %0d actual %0d", $time,
                           want.tick_result, got.tick_result);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            want = apply_request(req_type, req_worker_id, req_clock_value);
            pending_results.push_back(want);
            case (req_type)
               REQ_SET:  set_count++;
               REQ_TICK: begin
                  tick_count++;
                  if (want.tick_result != 0)
                     advance_count++;
                  if (want.worker_clock == CLOCK_MAX)
                     saturated_count++;
               end
               default:  read_count++;
            endcase
         end
      end
   end

   // Send one request; entered and left at a falling edge
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                               input logic [CLOCK_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_worker_id   <= id;
      req_clock_value <= value;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Fresh tracker: unknown workers, creation by tick, saturation at the top
   task automatic test_directed_startup();
      send_request(REQ_READ, 6'd0, 31'h0);
      send_request(REQ_READ_ALT, 6'd63, '1);
      send_request(REQ_TICK, 6'd5, '1);
      send_request(REQ_SET, 6'd0, CLOCK_MAX - 1'b1);
      send_request(REQ_TICK, 6'd0, 31'h0);
      send_request(REQ_TICK, 6'd0, 31'h0);
      send_request(REQ_READ, 6'd0, 31'h0);
   endtask

   // Minimum moves: lowering by set, shared and sole holders on tick
   task automatic test_directed_minimum();
      send_request(REQ_SET, 6'd1, 31'h0);
      send_request(REQ_TICK, 6'd1, 31'h0);
      send_request(REQ_TICK, 6'd1, 31'h0);
      send_request(REQ_TICK, 6'd5, 31'h0);
      send_request(REQ_TICK, 6'd63, 31'h0);
      send_request(REQ_SET, 6'd2, 31'd2);
      send_request(REQ_TICK, 6'd2, 31'h0);
      send_request(REQ_SET, 6'd63, 31'h5555_5555);
      send_request(REQ_SET, 6'd42, 31'h2AAA_AAAA);
      send_request(REQ_READ, 6'd42, 31'h0);
      send_request(REQ_READ_ALT, 6'd63, 31'h0);
      send_request(REQ_SET, 6'd3, 31'd1);
      send_request(REQ_READ, 6'd21, 31'h0);
   endtask

   // Set value: mostly around the current minimum, sometimes anywhere
   function automatic logic [CLOCK_W-1:0] draw_set_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5 && shadow_min >= 0 && shadow_min < 32'sh7FFF_FFF0)
         return shadow_min[CLOCK_W-1:0] + CLOCK_W'($urandom_range(0, 3));
      else if (sel < 7)
         return CLOCK_W'($urandom_range(0, 15));
      else if (sel < 9)
         return CLOCK_W'($urandom);
      else
         return CLOCK_MAX - CLOCK_W'($urandom_range(0, 3));
   endfunction

   // Random mix over a small worker pool, with occasional far ids
   task automatic test_random_mix(input int count);
      int                 pick;
      logic [REQ_W-1:0]   kind;
      logic [ID_W-1:0]    id;
      logic [CLOCK_W-1:0] value;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 45)
            kind = REQ_TICK;
         else if (pick < 65)
            kind = REQ_SET;
         else if (pick < 92)
            kind = REQ_READ;
         else
            kind = REQ_READ_ALT;
         if ($urandom_range(0, 4) == 0)
            id = ID_W'($urandom_range(0, TABLE_DEPTH - 1));
         else
            id = ID_W'($urandom_range(0, POOL_LAST));
         value = (kind == REQ_SET) ? draw_set_value() : CLOCK_W'($urandom);
         send_request(kind, id, value);
      end
      no_idle = 1'b0;
   endtask

   // Rounds: seed a pool near a common clock, then tick every worker in turn
   // so the minimum keeps advancing; reads and stray ticks break some rounds
   task automatic test_tick_rounds(input int count);
      int                 sent;
      int                 width;
      logic [CLOCK_W-1:0] base;
      sent = 0;
      while (sent < count) begin
         no_idle = ($urandom_range(0, 3) == 0);
         width = $urandom_range(1, POOL_LAST + 1);
         base = (shadow_min >= 0 && shadow_min < 32'sh7FFF_FF00) ?
                shadow_min[CLOCK_W-1:0] : CLOCK_W'($urandom_range(0, 31));
         for (int w = 0; w < width; w++) begin
            send_request(REQ_SET, ID_W'(w), base + CLOCK_W'($urandom_range(0, 1)));
            sent++;
         end
         repeat ($urandom_range(1, 4)) begin
            for (int w = 0; w < width; w++) begin
               if ($urandom_range(0, 9) == 0)
                  send_request(REQ_READ, ID_W'($urandom_range(0, TABLE_DEPTH - 1)),
                               CLOCK_W'($urandom));
               else if ($urandom_range(0, 19) == 0)
                  send_request(REQ_TICK, ID_W'($urandom_range(0, TABLE_DEPTH - 1)),
                               CLOCK_W'($urandom));
               else
                  send_request(REQ_TICK, ID_W'(w), CLOCK_W'($urandom));
               sent++;
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      shadow_min = NO_MIN;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_clock[i] = '0;
         shadow_known[i] = 1'b0;
      end

      // Reset, then requests wait on busy through the clearing sweep
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_startup();
      test_directed_minimum();
      test_random_mix(850);
      test_tick_rounds(580);

      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d sets, %0d ticks, %0d reads; %0d ticks advanced the minimum,",
               set_count, tick_count, read_count, advance_count);
      $display("%0d ticks ended at the saturated clock; %0d mismatches.",
               saturated_count, failures);
      if (failures == 0)
         $display("PASS worker_clock_min_tracker");
      else
         $display("FAIL worker_clock_min_tracker");
      $finish;
   end

endmodule
